// ===== design/d64q_pkg.sv =====
package d64q_pkg;

	localparam int unsigned WORD_W = 32;
	localparam int unsigned REM_W  = WORD_W + 1;

	// what travels down the divider pipe with each item
	typedef struct packed {
		logic [REM_W-1:0]  rem;
		logic [WORD_W-1:0] low;
		logic [WORD_W-1:0] den;
		logic [WORD_W-1:0] quo;
		logic              ovf;
	} stage_t;

	// one result waiting at the output
	typedef struct packed {
		logic [WORD_W-1:0] quo;
		logic              ovf;
	} result_t;

endpackage

// ===== design/d64q_step.sv =====
module d64q_step (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              valid_in,
	input  d64q_pkg::stage_t  data_in,
	output logic              valid_s1,
	output d64q_pkg::stage_t  data_s1
);

	logic [d64q_pkg::REM_W-1:0] shifted;
	logic [d64q_pkg::REM_W:0]   diff;
	logic                       fits;
	d64q_pkg::stage_t           nxt;

	// shift in next dividend bit, keep 33 bits, trial subtract
	assign shifted = {data_in.rem[d64q_pkg::REM_W-2:0], data_in.low[d64q_pkg::WORD_W-1]};
	assign diff    = {1'b0, shifted} - {2'b00, data_in.den};
	assign fits    = ~diff[d64q_pkg::REM_W];

	always_comb begin
		nxt     = data_in;
		nxt.rem = fits ? diff[d64q_pkg::REM_W-1:0] : shifted;
		nxt.low = {data_in.low[d64q_pkg::WORD_W-2:0], 1'b0};
		nxt.quo = {data_in.quo[d64q_pkg::WORD_W-2:0], fits};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_s1 <= nxt;
		end
	end

endmodule

// ===== design/d64q_out.sv =====
module d64q_out (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               valid_in,
	input  d64q_pkg::result_t  data_in,
	output logic               en,
	output logic               out_valid_q,
	output d64q_pkg::result_t  out_data_q,
	input  logic               out_stall
);

	logic              skid_valid_q;
	d64q_pkg::result_t skid_data_q;
	logic              take;
	logic              arrive;

	// pipe moves whenever the skid slot is free
	assign en     = ~skid_valid_q;
	assign take   = out_valid_q & ~out_stall;
	assign arrive = valid_in & en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (take) begin
				skid_valid_q <= 1'b0;
			end
		end else if (!out_valid_q || take) begin
			out_valid_q <= arrive;
		end else if (arrive) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (take) begin
				out_data_q <= skid_data_q;
			end
		end else if (!out_valid_q || take) begin
			out_data_q <= data_in;
		end else begin
			skid_data_q <= data_in;
		end
	end

endmodule

// ===== design/divide_64_by_32_quotient_core.sv =====
// unsigned 64 by 32 restoring divider, quotient only
//
// input channel: in_valid / in_stall carry one item made of dividend_upper,
// dividend_lower and divisor; an item is taken at a clock edge with in_valid
// high and in_stall low
// output channel: out_valid / out_stall carry quotient and overflow
// overflow is set when dividend_upper >= divisor (a zero divisor included);
// the quotient is then whatever the restoring steps give
//
// pipeline: from acceptance to out_valid an item passes one pipeline
// register per quotient bit plus the output register
// throughput: one item per cycle while in_stall is low; each stage holds one 33-bit trial subtract
//
// a stalled result sits in the output register; one more item lands in a
// skid register, and only then does in_stall rise and the whole pipe freeze
// reset clears every valid bit; nothing else needs clearing
module divide_64_by_32_quotient_core #(
	parameter int unsigned QUOTIENT_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] dividend_upper,
	input  logic [31:0] dividend_lower,
	input  logic [31:0] divisor,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] quotient,
	output logic        overflow
);

	// pipe stage k feeds stage k+1; index 0 is the input item itself
	logic              pipe_valid [0:QUOTIENT_BITS];
	d64q_pkg::stage_t  pipe_data  [0:QUOTIENT_BITS];
	logic              en;
	d64q_pkg::result_t last_res;
	d64q_pkg::result_t out_res;

	// upper word starts as the partial remainder, the overflow check runs
	// beside the first step
	always_comb begin
		pipe_valid[0]    = in_valid;
		pipe_data[0].rem = {1'b0, dividend_upper};
		pipe_data[0].low = dividend_lower;
		pipe_data[0].den = divisor;
		pipe_data[0].quo = '0;
		pipe_data[0].ovf = (dividend_upper >= divisor);
	end

	// one restoring step per quotient bit
	for (genvar k = 0; k < QUOTIENT_BITS; k++) begin : g_step
		d64q_step u_step (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.valid_in (pipe_valid[k]),
			.data_in  (pipe_data[k]),
			.valid_s1 (pipe_valid[k+1]),
			.data_s1  (pipe_data[k+1])
		);
	end

	assign last_res.quo = pipe_data[QUOTIENT_BITS].quo;
	assign last_res.ovf = pipe_data[QUOTIENT_BITS].ovf;

	// output register with a skid slot behind it
	d64q_out u_out (
		.clk         (clk),
		.arst_n      (arst_n),
		.valid_in    (pipe_valid[QUOTIENT_BITS]),
		.data_in     (last_res),
		.en          (en),
		.out_valid_q (out_valid),
		.out_data_q  (out_res),
		.out_stall   (out_stall)
	);

	assign in_stall = ~en;
	assign quotient = out_res.quo;
	assign overflow = out_res.ovf;

endmodule

// ===== design/d64q_chk.sv =====
module d64q_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [31:0] quotient,
	input logic        overflow
);

	// nothing pending or blocked while in reset
	a_reset_idle: assert property (@(posedge clk)
		!arst_n |-> (!out_valid && !in_stall))
		else $error("output valid or input stall during reset");

	// input only backs up when a result is waiting at the output
	a_stall_needs_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled with no result waiting");

	// skid slot fills only behind a stalled result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(in_stall) |-> $past(out_valid && out_stall))
		else $error("input stall without a stalled output");

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(quotient) && $stable(overflow)))
		else $error("stalled result changed or dropped");

endmodule

bind divide_64_by_32_quotient_core d64q_chk u_d64q_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.quotient  (quotient),
	.overflow  (overflow)
);
